// File: rtl/core/tfc_pkg.sv
`timescale 1ns / 1ps

package tfc_pkg;

  // sample width and comparison width (room for sign and a difference)
  localparam int SAMPLE_BITS   = 16;
  localparam int CMP_BITS      = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int DUTY_BITS     = 9;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HYSTERESIS  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SLEW_LIMIT  = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FAULT_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VALID_HIGH  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VALID_LOW   = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OFF_TICKS   = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ON_TICKS    = 3'd7;

  // result status codes
  localparam logic [1:0] STS_ACCEPTED = 2'd0;
  localparam logic [1:0] STS_SLEW     = 2'd1;
  localparam logic [1:0] STS_WINDOW   = 2'd2;
  localparam logic [1:0] STS_FAULT    = 2'd3;

  typedef struct packed {
    logic signed [15:0] valid_high;
    logic signed [15:0] valid_low;
    logic [9:0]         slew_limit;
    logic [7:0]         fault_limit;
  } front_cfg_t;

  typedef struct packed {
    logic [9:0] setpoint;
    logic [7:0] hysteresis;
    logic [7:0] off_ticks;
    logic [7:0] on_ticks;
  } back_cfg_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [1:0]                    status;
    logic signed [SAMPLE_BITS-1:0] sample;
  } word_t;

endpackage

// File: rtl/core/tfc_front.sv
`timescale 1ns / 1ps

module tfc_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tfc_pkg::front_cfg_t                    cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tfc_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   q_valid,
  input  logic                                   q_ready,
  output tfc_pkg::word_t                         q_word
);
  import tfc_pkg::*;

  logic signed [SAMPLE_BITS-1:0] last_valid_r, last_valid_nxt;
  logic [7:0]                    fault_count_r, fault_count_nxt;
  logic signed [CMP_BITS-1:0]    s_ext, last_ext, hi_ext, lo_ext, lim_ext, diff;
  logic [7:0]                    fault_inc;
  logic                          in_window, slew_ok, accept;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;

  always_comb begin
    s_ext     = CMP_BITS'(in_sample);
    last_ext  = CMP_BITS'(last_valid_r);
    hi_ext    = CMP_BITS'(cfg.valid_high);
    lo_ext    = CMP_BITS'(cfg.valid_low);
    lim_ext   = CMP_BITS'(signed'({1'b0, cfg.slew_limit}));
    diff      = s_ext - last_ext;
    in_window = (s_ext < hi_ext) && (s_ext > lo_ext);
    slew_ok   = (diff < lim_ext) && (diff > -lim_ext);
    fault_inc = (fault_count_r == 8'hFF) ? fault_count_r : fault_count_r + 8'd1;

    last_valid_nxt  = last_valid_r;
    fault_count_nxt = fault_count_r;
    q_word.sample   = in_sample;
    if (in_window) begin
      last_valid_nxt = in_sample;
      if (slew_ok) begin
        fault_count_nxt = 8'd0;
        q_word.status   = STS_ACCEPTED;
      end else begin
        q_word.status   = STS_SLEW;
      end
    end else begin
      fault_count_nxt = fault_inc;
      q_word.status   = (fault_inc > cfg.fault_limit) ? STS_FAULT : STS_WINDOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r  <= '0;
      fault_count_r <= '0;
    end else if (accept) begin
      last_valid_r  <= last_valid_nxt;
      fault_count_r <= fault_count_nxt;
    end
  end

endmodule

// File: rtl/core/tfc_queue.sv
`timescale 1ns / 1ps

module tfc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tfc_pkg::word_t push_word,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tfc_pkg::word_t pop_word
);
  import tfc_pkg::*;

  word_t      entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_word   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/tfc_back.sv
`timescale 1ns / 1ps

module tfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tfc_pkg::back_cfg_t cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  tfc_pkg::word_t     q_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_heater_on,
  output logic               out_fan_on,
  output logic               out_reached,
  output logic [1:0]         out_status
);
  import tfc_pkg::*;

  logic                       out_valid_r;
  logic                       heater_r, heater_nxt;
  logic                       fan_r, fan_nxt;
  logic                       reached_r, reached_nxt;
  logic [DUTY_BITS-1:0]       duty_r, duty_nxt, duty_inc, duty_top;
  logic [1:0]                 status_r;
  logic signed [CMP_BITS-1:0] s_ext, sp_ext, hyst_ext;
  logic                       below, pop;

  assign q_ready       = !out_valid_r || out_ready;
  assign pop           = q_valid && q_ready;
  assign out_valid     = out_valid_r;
  assign out_heater_on = heater_r;
  assign out_fan_on    = fan_r;
  assign out_reached   = reached_r;
  assign out_status    = status_r;

  always_comb begin
    s_ext    = CMP_BITS'(q_word.sample);
    sp_ext   = CMP_BITS'(signed'({1'b0, cfg.setpoint}));
    hyst_ext = CMP_BITS'(signed'({1'b0, cfg.hysteresis}));
    below    = s_ext < sp_ext;
    duty_inc = duty_r + DUTY_BITS'(1);
    duty_top = DUTY_BITS'(cfg.off_ticks) + DUTY_BITS'(cfg.on_ticks);

    heater_nxt  = heater_r;
    fan_nxt     = fan_r;
    reached_nxt = reached_r;
    duty_nxt    = duty_r;
    case (q_word.status)
      STS_ACCEPTED: begin
        // hysteresis: clear on a drop, set at setpoint
        if ((sp_ext - s_ext) >= hyst_ext) reached_nxt = 1'b0;
        if (!below) reached_nxt = 1'b1;
        fan_nxt = below;
        if (!below) begin
          heater_nxt = 1'b0;
        end else if (!reached_nxt) begin
          heater_nxt = 1'b1;
        end else if (duty_inc < DUTY_BITS'(cfg.off_ticks)) begin
          heater_nxt = 1'b0;
          duty_nxt   = duty_inc;
        end else begin
          heater_nxt = 1'b1;
          duty_nxt   = (duty_inc > duty_top) ? '0 : duty_inc;
        end
      end
      STS_FAULT: heater_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      heater_r    <= 1'b0;
      fan_r       <= 1'b0;
      reached_r   <= 1'b0;
      duty_r      <= '0;
      status_r    <= STS_ACCEPTED;
    end else begin
      if (q_ready) out_valid_r <= q_valid;
      if (pop) begin
        heater_r  <= heater_nxt;
        fan_r     <= fan_nxt;
        reached_r <= reached_nxt;
        duty_r    <= duty_nxt;
        status_r  <= q_word.status;
      end
    end
  end

endmodule

// File: rtl/core/thermostat_heater_fan_control.sv
`timescale 1ns / 1ps

// thermostat heater and fan control: one signed temperature sample (tenths of
// a degree) goes in per word and one status word comes out per sample. the
// front stage checks the sample against the valid window and the slew limit,
// tracks the last in-window sample and the saturating fault count, and tags
// the word with its status; a two-entry queue decouples it from the back
// stage, which runs the hysteresis flag, the duty counter and the latched
// heater and fan drives, and holds the result in an output register. the
// block takes one word per cycle and returns one result per cycle as long as
// the output side keeps up; a result is written into the queue entry and then
// into the output register after its sample is taken. configuration writes go
// through the cfg_ port, one register per cycle, and should only be made
// while no sample is in flight.
module thermostat_heater_fan_control (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // configuration port
  input  logic                                      cfg_wr_en,
  input  logic [tfc_pkg::CFG_ADDR_BITS-1:0]         cfg_addr,
  input  logic [tfc_pkg::CFG_DATA_BITS-1:0]         cfg_wdata,
  // sample input
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [tfc_pkg::SAMPLE_BITS-1:0]    in_sample,
  // result output
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      out_heater_on,
  output logic                                      out_fan_on,
  output logic                                      out_reached,
  output logic [1:0]                                out_status
);
  import tfc_pkg::*;

  // configuration registers with their reset values
  logic [9:0]         setpoint_r;
  logic [7:0]         hysteresis_r;
  logic [9:0]         slew_limit_r;
  logic [7:0]         fault_limit_r;
  logic signed [15:0] valid_high_r;
  logic signed [15:0] valid_low_r;
  logic [7:0]         off_ticks_r;
  logic [7:0]         on_ticks_r;

  front_cfg_t front_cfg;
  back_cfg_t  back_cfg;

  // front to queue, queue to back
  logic  f_valid, f_ready;
  word_t f_word;
  logic  b_valid, b_ready;
  word_t b_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= 10'd380;
      hysteresis_r  <= 8'd3;
      slew_limit_r  <= 10'd20;
      fault_limit_r <= 8'd10;
      valid_high_r  <= 16'sd2000;
      valid_low_r   <= -16'sd200;
      off_ticks_r   <= 8'd50;
      on_ticks_r    <= 8'd40;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SETPOINT:    setpoint_r    <= cfg_wdata[9:0];
        REG_HYSTERESIS:  hysteresis_r  <= cfg_wdata[7:0];
        REG_SLEW_LIMIT:  slew_limit_r  <= cfg_wdata[9:0];
        REG_FAULT_LIMIT: fault_limit_r <= cfg_wdata[7:0];
        REG_VALID_HIGH:  valid_high_r  <= signed'(cfg_wdata);
        REG_VALID_LOW:   valid_low_r   <= signed'(cfg_wdata);
        REG_OFF_TICKS:   off_ticks_r   <= cfg_wdata[7:0];
        REG_ON_TICKS:    on_ticks_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    front_cfg.valid_high  = valid_high_r;
    front_cfg.valid_low   = valid_low_r;
    front_cfg.slew_limit  = slew_limit_r;
    front_cfg.fault_limit = fault_limit_r;
    back_cfg.setpoint     = setpoint_r;
    back_cfg.hysteresis   = hysteresis_r;
    back_cfg.off_ticks    = off_ticks_r;
    back_cfg.on_ticks     = on_ticks_r;
  end

  // classify: window, slew, fault count
  tfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (front_cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_word    (f_word)
  );

  // two-entry decoupling queue
  tfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_word   (b_word)
  );

  // control: hysteresis, duty cycle, latched drives
  tfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (back_cfg),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_word        (b_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_heater_on (out_heater_on),
    .out_fan_on    (out_fan_on),
    .out_reached   (out_reached),
    .out_status    (out_status)
  );

endmodule
